/* hdl/cis_pkg.sv */
package cis_pkg;

  localparam int unsigned PatternMax = 16;
  localparam int unsigned PosWidth   = 16;
  localparam int unsigned LenWidth   = $clog2(PatternMax + 1);
  localparam int unsigned IdxWidth   = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned StartWidth = 16;
  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  typedef logic [PatternMax-1:0][7:0] pattern_t;

  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [StartWidth-1:0] start;
  } result_t;

  // ASCII A-Z to lower case, everything else unchanged
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

/* hdl/cis_cfg.sv */
module cis_cfg
  import cis_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready,
  output pattern_t                fold_pat_o,
  output logic [LenWidth-1:0]     eff_len_o
);

  logic [63:0] pat_low_q;
  logic [63:0] pat_high_q;
  logic [4:0]  pat_len_q;
  reg_idx_e    reg_idx;
  logic        wr_en;

  pattern_t            fold_pat_d, fold_pat_q;
  logic [LenWidth-1:0] eff_len_d, eff_len_q;
  logic [127:0]        raw_pat;
  logic [LenWidth-1:0] lim;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:    pat_low_q  <= pwdata[63:0];
        REG_PATTERN_HIGH:   pat_high_q <= pwdata[63:0];
        REG_PATTERN_LENGTH: pat_len_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:    prdata = pat_low_q;
      REG_PATTERN_HIGH:   prdata = pat_high_q;
      REG_PATTERN_LENGTH: prdata = {{(CfgDataWidth-5){1'b0}}, pat_len_q};
      default:            prdata = '0;
    endcase
  end

  assign raw_pat = {pat_high_q, pat_low_q};

  // Effective length: clamp, then cut at the first zero byte.
  always_comb begin
    if ({1'b0, pat_len_q} > 6'(PatternMax)) begin
      lim = LenWidth'(PatternMax);
    end else begin
      lim = LenWidth'(pat_len_q);
    end
    eff_len_d = lim;
    for (int i = PatternMax - 1; i >= 0; i--) begin
      fold_pat_d[i] = fold(raw_pat[i*8 +: 8]);
      if (LenWidth'(i) < lim && raw_pat[i*8 +: 8] == 8'h00) begin
        eff_len_d = LenWidth'(i);
      end
    end
  end

  // User must change registers only while idle; it is not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q  <= '0;
      fold_pat_q <= '0;
    end else begin
      eff_len_q  <= eff_len_d;
      fold_pat_q <= fold_pat_d;
    end
  end

  assign fold_pat_o = fold_pat_q;
  assign eff_len_o  = eff_len_q;

endmodule

/* hdl/cis_match.sv */
module cis_match
  import cis_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  pattern_t            fold_pat_i,
  input  logic [LenWidth-1:0] eff_len_i,
  output result_t             res_o
);

  // window of folded text bytes, newest at index 0
  pattern_t              win_d, win_q;
  logic [PatternMax-1:0] eq;
  logic [PosWidth-1:0]   pos_q;
  logic                  reported_q;
  logic                  hit;
  logic [PosWidth:0]     count;
  logic [PosWidth:0]     start_full;

  if (PatternMax > 1) begin : g_shift
    assign win_d = {win_q[PatternMax-2:0], byte_i};
  end else begin : g_single
    assign win_d = byte_i;
  end

  // pattern byte i lines up with window entry len-1-i; bytes past len always agree
  always_comb begin
    for (int i = 0; i < PatternMax; i++) begin
      eq[i] = (LenWidth'(i) >= eff_len_i) ||
              (win_d[IdxWidth'(eff_len_i - LenWidth'(i + 1))] == fold_pat_i[i]);
    end
  end

  assign count      = {1'b0, pos_q} + (PosWidth+1)'(1);
  assign hit        = (eff_len_i != '0) && (count >= (PosWidth+1)'(eff_len_i)) && (&eq);
  assign start_full = count - (PosWidth+1)'(eff_len_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      pos_q      <= '0;
      reported_q <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        win_q      <= '0;
        pos_q      <= '0;
        reported_q <= 1'b0;
      end else if (!reported_q) begin
        win_q <= win_d;
        if (pos_q != '1) begin
          pos_q <= pos_q + PosWidth'(1);
        end
        if (hit) begin
          reported_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.valid = fire_i && !reported_q && (hit || last_i);
    res_o.found = hit;
    res_o.start = '0;
    if (hit) begin
      if (start_full > (PosWidth+1)'({StartWidth{1'b1}})) begin
        res_o.start = '1;
      end else begin
        res_o.start = StartWidth'(start_full);
      end
    end
  end

endmodule

/* hdl/case_insensitive_substring_search.sv */
// Case-insensitive substring search over a byte stream.
// An accepted item passes through the input register, then through the match logic into
// the result register, from which any result that it causes is presented.
// Throughput: one item per cycle; a result held by a stalled receiver stops input once
// the input register also holds an item. Reset clears the pattern registers, the match
// state and both stages.
module case_insensitive_substring_search
  import cis_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              text_byte_i,
  input  logic                    is_last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    found_o,
  output logic [StartWidth-1:0]   match_start_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  pattern_t            fold_pat;
  logic [LenWidth-1:0] eff_len;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       advance;
  logic       in_fire;

  result_t         res;
  logic            out_valid_q;
  logic            out_found_q;
  logic [StartWidth-1:0] out_start_q;

  cis_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fold_pat_o (fold_pat),
    .eff_len_o  (eff_len)
  );

  // stage 1 item moves on when the result register is free or being taken
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= fold(text_byte_i);
      s1_last_q <= is_last_i;
    end
  end

  cis_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .byte_i     (s1_byte_q),
    .last_i     (s1_last_q),
    .fold_pat_i (fold_pat),
    .eff_len_i  (eff_len),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_found_q <= res.found;
      out_start_q <= res.start;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign match_start_o = out_start_q;

endmodule
